[rtl/core/acpu_pkg.sv]
// ----------------------------------------------------------------------------
// acpu_pkg: shared types and constants of the accumulator processor
// Holds operation codes, instruction opcodes, flag bit positions and the
// request/result structs passed between the sequencer, stores and ALU.
// ----------------------------------------------------------------------------
package acpu_pkg;

	// Store geometry (depths are powers of two)
	localparam int MEM_DEPTH = 2048;
	localparam int IO_DEPTH  = 32;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int IO_AW     = $clog2(IO_DEPTH);

	// Field widths
	localparam int PC_W  = 11;
	localparam int DW    = 8;
	localparam int OPC_W = 5;
	localparam int FL_W  = 4;

	// Flag bit positions
	localparam int FL_ZERO  = 0;
	localparam int FL_CARRY = 1;
	localparam int FL_SIGN  = 2;
	localparam int FL_OVER  = 3;

	// Item operations
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_READ = 2'd1,
		OP_EXEC = 2'd2,
		OP_IORD = 2'd3
	} op_t;

	// Instruction opcodes
	typedef enum logic [OPC_W-1:0] {
		OPC_WM   = 5'h01,
		OPC_RM   = 5'h02,
		OPC_BR   = 5'h03,
		OPC_RIO  = 5'h04,
		OPC_WIO  = 5'h05,
		OPC_WB   = 5'h06,
		OPC_WIB  = 5'h07,
		OPC_WACC = 5'h09,
		OPC_RACC = 5'h0B,
		OPC_SWAP = 5'h0E,
		OPC_BRLT = 5'h11,
		OPC_BRGT = 5'h12,
		OPC_BRNE = 5'h13,
		OPC_BRE  = 5'h14,
		OPC_SHR  = 5'h15,
		OPC_SHL  = 5'h16,
		OPC_XOR  = 5'h17,
		OPC_NOT  = 5'h18,
		OPC_OR   = 5'h19,
		OPC_AND  = 5'h1A,
		OPC_MUL  = 5'h1B,
		OPC_SUB  = 5'h1D,
		OPC_ADD  = 5'h1E,
		OPC_EOP  = 5'h1F
	} opc_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_FETCH_LO,
		ST_DECODE,
		ST_RDWAIT,
		ST_RESP
	} state_t;

	// Main store port request
	typedef struct packed {
		logic              en;
		logic              we;
		logic [MEM_AW-1:0] addr;
		logic [DW-1:0]     wdata;
	} mem_req_t;

	// I/O store port request
	typedef struct packed {
		logic             we;
		logic [IO_AW-1:0] addr;
		logic [DW-1:0]    wdata;
	} io_req_t;

	// ALU result
	typedef struct packed {
		logic [DW-1:0]   acc;
		logic [FL_W-1:0] flags;
		logic            take;
	} alu_res_t;

endpackage

[rtl/core/acpu_mem.sv]
// ----------------------------------------------------------------------------
// acpu_mem: main byte store
// Single-port synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module acpu_mem import acpu_pkg::*; (
	input  logic          clk,
	input  mem_req_t      req,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [MEM_DEPTH];

	// Write or read one byte per cycle
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata <= mem[req.addr];
			end
		end
	end

endmodule

[rtl/core/acpu_io.sv]
// ----------------------------------------------------------------------------
// acpu_io: I/O byte store
// Small register file cleared at reset, one address shared by write and read.
// ----------------------------------------------------------------------------
module acpu_io import acpu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  io_req_t       req,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] regs_q [IO_DEPTH];

	// Clear at reset, write on request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < IO_DEPTH; i++) begin
				regs_q[i] <= '0;
			end
		end else if (req.we) begin
			regs_q[req.addr] <= req.wdata;
		end
	end

	// Read the addressed byte
	assign rdata = regs_q[req.addr];

endmodule

[rtl/core/acpu_alu.sv]
// ----------------------------------------------------------------------------
// acpu_alu: shared arithmetic and logic unit
// Computes the new accumulator, flags and branch decision for one opcode.
// ----------------------------------------------------------------------------
module acpu_alu import acpu_pkg::*; (
	input  logic [OPC_W-1:0] opc,
	input  logic [DW-1:0]    acc,
	input  logic [DW-1:0]    mbr,
	input  logic [FL_W-1:0]  flags,
	output alu_res_t         res
);

	logic [DW:0]     sum;
	logic [DW:0]     diff;
	logic [2*DW-1:0] prod;
	logic [DW-1:0]   neg;
	logic [DW-1:0]   logic_r;
	logic [FL_W-1:0] full_fl;
	logic [DW-1:0]   full_r;
	logic            full_c;

	// Arithmetic results with carry out
	always_comb begin
		neg  = DW'(0) - mbr;
		sum  = {1'b0, acc} + {1'b0, mbr};
		diff = {1'b0, acc} + {1'b0, neg};
		prod = acc * mbr;
	end

	// Select the arithmetic result for the full flag update
	always_comb begin
		case (opc)
			OPC_MUL: begin
				full_r = prod[DW-1:0];
				full_c = |prod[2*DW-1:DW];
			end
			OPC_ADD: begin
				full_r = sum[DW-1:0];
				full_c = sum[DW];
			end
			default: begin
				full_r = diff[DW-1:0];
				full_c = diff[DW];
			end
		endcase
		full_fl            = '0;
		full_fl[FL_ZERO]   = (full_r == '0);
		full_fl[FL_CARRY]  = full_c;
		full_fl[FL_OVER]   = full_c;
		full_fl[FL_SIGN]   = full_r[DW-1];
	end

	// Produce accumulator, flags and branch decision
	always_comb begin
		res       = '0;
		res.acc   = acc;
		res.flags = flags;
		logic_r   = acc;
		case (opc)
			OPC_BRLT, OPC_BRGT, OPC_BRNE, OPC_BRE, OPC_SUB, OPC_MUL, OPC_ADD: begin
				res.acc   = full_r;
				res.flags = full_fl;
				case (opc)
					OPC_BRLT: res.take = full_fl[FL_SIGN];
					OPC_BRGT: res.take = !full_fl[FL_SIGN] && !full_fl[FL_ZERO];
					OPC_BRNE: res.take = !full_fl[FL_ZERO];
					OPC_BRE:  res.take = full_fl[FL_ZERO];
					default:  res.take = 1'b0;
				endcase
			end
			OPC_SHR: begin
				res.flags[FL_CARRY] = acc[0];
				res.acc             = acc >> 1;
			end
			OPC_SHL: begin
				res.flags[FL_CARRY] = acc[DW-1];
				res.acc             = acc << 1;
			end
			OPC_XOR, OPC_NOT, OPC_OR, OPC_AND: begin
				case (opc)
					OPC_XOR: logic_r = acc ^ mbr;
					OPC_NOT: logic_r = ~acc;
					OPC_OR:  logic_r = acc | mbr;
					default: logic_r = acc & mbr;
				endcase
				res.acc            = logic_r;
				res.flags[FL_ZERO] = (logic_r == '0);
			end
			default: begin
				res.acc = acc;
			end
		endcase
	end

endmodule

[rtl/core/accumulator_cpu_step.sv]
// ----------------------------------------------------------------------------
// accumulator_cpu_step: 8-bit accumulator processor, one operation per beat
// Memory load, I/O read and halted execute go ISSUE to RESP; memory read adds
// RDWAIT; instruction execute runs ISSUE, FETCH_LO, DECODE, and RM adds RDWAIT.
// The single-port main store serves two instruction byte fetches plus one data
// access; a new beat is taken only once the last reaches done. busy drops while
// done is high; done cannot stall. Reset clears state, core regs, I/O store.
// ----------------------------------------------------------------------------
module accumulator_cpu_step import acpu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       op,
	input  logic [10:0]      address,
	input  logic [7:0]       data,
	output logic             done,
	output logic [7:0]       read_data,
	output logic [10:0]      pc,
	output logic [7:0]       acc,
	output logic [3:0]       flags,
	output logic [7:0]       mbr,
	output logic [7:0]       iobr,
	output logic             halted,
	output logic             fault
);

	state_t          state_q, state_d;
	logic [1:0]      op_q;
	logic [PC_W-1:0] addr_q;
	logic [DW-1:0]   data_q;
	logic [DW-1:0]   hi_q;
	logic [DW-1:0]   rd_q;
	logic [PC_W-1:0] pc_q;
	logic [DW-1:0]   acc_q;
	logic [FL_W-1:0] flags_q;
	logic [DW-1:0]   mbr_q;
	logic [DW-1:0]   iobr_q;
	logic            halted_q;
	logic            fault_q;

	mem_req_t        mem_req;
	logic [DW-1:0]   mem_rdata;
	io_req_t         io_req;
	logic [DW-1:0]   io_rdata;
	alu_res_t        alu_res;
	logic [OPC_W-1:0] opc;
	logic [PC_W-1:0] opd;
	logic            accept;

	// Decode the instruction word as the low byte returns
	assign opc    = hi_q[DW-1:DW-OPC_W];
	assign opd    = {hi_q[PC_W-DW-1:0], mem_rdata};
	assign accept = start && !busy;

	acpu_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	acpu_io u_io (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (io_req),
		.rdata  (io_rdata)
	);

	acpu_alu u_alu (
		.opc   (opc),
		.acc   (acc_q),
		.mbr   (mbr_q),
		.flags (flags_q),
		.res   (alu_res)
	);

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence the beat and drive store requests
	always_comb begin
		state_d        = state_q;
		mem_req        = '0;
		io_req         = '0;
		io_req.addr    = addr_q[IO_AW-1:0];
		io_req.wdata   = iobr_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				state_d = ST_RESP;
				case (op_q)
					OP_LOAD: begin
						mem_req.en    = 1'b1;
						mem_req.we    = 1'b1;
						mem_req.addr  = addr_q[MEM_AW-1:0];
						mem_req.wdata = data_q;
					end
					OP_READ: begin
						mem_req.en   = 1'b1;
						mem_req.addr = addr_q[MEM_AW-1:0];
						state_d      = ST_RDWAIT;
					end
					OP_EXEC: begin
						if (!halted_q) begin
							mem_req.en   = 1'b1;
							mem_req.addr = pc_q[MEM_AW-1:0];
							state_d      = ST_FETCH_LO;
						end
					end
					default: ;
				endcase
			end
			ST_FETCH_LO: begin
				mem_req.en   = 1'b1;
				mem_req.addr = pc_q[MEM_AW-1:0];
				state_d      = ST_DECODE;
			end
			ST_DECODE: begin
				state_d     = ST_RESP;
				io_req.addr = opd[IO_AW-1:0];
				case (opc)
					OPC_WM: begin
						mem_req.en    = 1'b1;
						mem_req.we    = 1'b1;
						mem_req.addr  = opd[MEM_AW-1:0];
						mem_req.wdata = mbr_q;
					end
					OPC_RM: begin
						mem_req.en   = 1'b1;
						mem_req.addr = opd[MEM_AW-1:0];
						state_d      = ST_RDWAIT;
					end
					OPC_WIO: io_req.we = 1'b1;
					default: ;
				endcase
			end
			ST_RDWAIT: state_d = ST_RESP;
			ST_RESP: begin
				state_d = start ? ST_ISSUE : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Latch the accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			addr_q <= address;
			data_q <= data;
		end
		if (state_q == ST_FETCH_LO) begin
			hi_q <= mem_rdata;
		end
	end

	// Update architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q     <= '0;
			pc_q     <= '0;
			acc_q    <= '0;
			flags_q  <= '0;
			mbr_q    <= '0;
			iobr_q   <= '0;
			halted_q <= 1'b0;
			fault_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_ISSUE: begin
					rd_q <= (op_q == OP_IORD) ? io_rdata : '0;
					if (op_q == OP_EXEC && !halted_q) pc_q <= pc_q + PC_W'(1);
				end
				ST_FETCH_LO: pc_q <= pc_q + PC_W'(1);
				ST_DECODE: begin
					case (opc)
						OPC_WM, OPC_RM, OPC_WIO: ;
						OPC_BR:   pc_q   <= opd;
						OPC_RIO:  iobr_q <= io_rdata;
						OPC_WB:   mbr_q  <= opd[DW-1:0];
						OPC_WIB:  iobr_q <= opd[DW-1:0];
						OPC_WACC: acc_q  <= mbr_q;
						OPC_RACC: mbr_q  <= acc_q;
						OPC_SWAP: begin
							mbr_q  <= iobr_q;
							iobr_q <= mbr_q;
						end
						OPC_BRLT, OPC_BRGT, OPC_BRNE, OPC_BRE, OPC_SHR, OPC_SHL,
						OPC_XOR, OPC_NOT, OPC_OR, OPC_AND, OPC_MUL, OPC_SUB,
						OPC_ADD: begin
							acc_q   <= alu_res.acc;
							flags_q <= alu_res.flags;
							if (alu_res.take) pc_q <= opd;
						end
						OPC_EOP: halted_q <= 1'b1;
						default: begin
							halted_q <= 1'b1;
							fault_q  <= 1'b1;
						end
					endcase
				end
				ST_RDWAIT: begin
					if (op_q == OP_READ) begin
						rd_q <= mem_rdata;
					end else begin
						mbr_q <= mem_rdata;
					end
				end
				default: ;
			endcase
		end
	end

	// Drive the result ports
	assign busy      = (state_q != ST_IDLE) && (state_q != ST_RESP);
	assign done      = (state_q == ST_RESP);
	assign read_data = rd_q;
	assign pc        = pc_q;
	assign acc       = acc_q;
	assign flags     = flags_q;
	assign mbr       = mbr_q;
	assign iobr      = iobr_q;
	assign halted    = halted_q;
	assign fault     = fault_q;

	// A fault always comes with a halt
	a_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |-> halted_q)
		else $error("fault set without halt");

	// An accepted beat puts the sequencer to work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted beat left sequencer idle");

	// Execute while halted answers at once and leaves pc alone
	a_halted_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE && op_q == OP_EXEC && halted_q) |=>
		(state_q == ST_RESP && $stable(pc_q)))
		else $error("halted machine executed");

	// Halt is raised only by instruction decode
	a_halt_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(halted_q) |-> $past(state_q) == ST_DECODE)
		else $error("halt raised outside decode");

endmodule
